// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define SKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- hw/rtl/skc_pkg.sv -----
`default_nettype none

package skc_pkg;

  localparam int STAMP_W    = 32;
  localparam int SIZE_W     = 16;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int GAIN_W     = 18;
  localparam int AGE_W      = 24;
  localparam int ETHR_W     = 15;
  localparam int RTHR_W     = 31;
  localparam int AMP_W      = 20;
  localparam int OPND_W     = 32;
  localparam int PROD_W     = 64;
  localparam int NUM_W      = 38;
  localparam int DEN_W      = 32;
  localparam int AMP_SHIFT  = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [OPND_W-1:0] US_PER_S = 32'd1000000;
  localparam logic [AMP_W-1:0]  AMP_MAX  = 20'hFFFFF;

  // Largest magnitudes a signed 32-bit rate can carry, on either side of zero.
  localparam logic [NUM_W-1:0] RATE_POS_MAX = 38'h00_7FFF_FFFF;
  localparam logic [NUM_W-1:0] RATE_NEG_MAX = 38'h00_8000_0000;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_RST      = 18'd26214;
  localparam logic [AGE_W-1:0]  MAX_AGE_RST   = 24'd500000;
  localparam logic [AGE_W-1:0]  PATIENCE_RST  = 24'd400000;
  localparam logic [ETHR_W-1:0] ERR_THR_RST   = 15'd123;
  localparam logic [RTHR_W-1:0] RATE_THR_RST  = 31'd82;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATIENCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_THR = 3'd4;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [ERR_W-1:0]   error;
  } hist_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EVICT  = 9'b000000010,
    S_NUM    = 9'b000000100,
    S_DSTART = 9'b000001000,
    S_DIV    = 9'b000010000,
    S_APPEND = 9'b000100000,
    S_SQ     = 9'b001000000,
    S_AMP    = 9'b010000000,
    S_OUT    = 9'b100000000
  } seq_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/size_keeping_speed_corrector_top.sv -----
`default_nettype none

// Speed corrector that keeps a tracked object at a target angular size. Each request
// carries a microsecond stamp, a measured and a target size (Q12 radians); it may yield
// one correction amplitude (Q12, saturated). The block handles one request at a time
// and holds in_stall high until it is done. A sweep over the history memory, which holds
// at most HISTORY_DEPTH entries, drops aged entries, one entry a cycle. When an error
// rate can be formed, it then needs one pass of the bit-serial divider; a correction
// adds the squaring and gain steps on the shared multiplier. A finished amplitude sits in
// an output register, so the next request may enter while it waits. The history needs
// no clearing pass after reset.
module size_keeping_speed_corrector_top import skc_pkg::*; #(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [STAMP_W-1:0]    in_stamp_us,
  input  wire logic signed [SIZE_W-1:0] in_measured_size,
  input  wire logic signed [SIZE_W-1:0] in_target_size,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [AMP_W-1:0]      out_amplitude,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers.
  logic [GAIN_W-1:0] gain_r;
  logic [AGE_W-1:0]  max_age_r;
  logic [AGE_W-1:0]  patience_r;
  logic [ETHR_W-1:0] err_thr_r;
  logic [RTHR_W-1:0] rate_thr_r;

  // Sequencer and per-request registers.
  seq_state_t         state_r;
  seq_state_t         state_nxt;
  logic [STAMP_W-1:0] stamp_r;
  logic [ERR_W-1:0]   err_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic [IDX_W-1:0]   rd_ptr_r;
  logic [IDX_W-1:0]   wr_ptr_r;
  logic [CNT_W-1:0]   kept_r;
  logic               pv_r;
  logic [STAMP_W-1:0] old_stamp_r;
  logic [ERR_W-1:0]   old_err_r;
  logic               diff_neg_r;
  logic               rate_on_r;

  // History state.
  logic [IDX_W-1:0]   head_r;
  logic [CNT_W-1:0]   count_r;
  logic [STAMP_W-1:0] last_stamp_r;
  logic               corrected_r;

  logic               out_valid_r;
  logic [AMP_W-1:0]   out_amp_r;

  // History memory.
  hist_entry_t        hist_mem [HISTORY_DEPTH];
  hist_entry_t        rd_data_r;
  logic               mem_we;
  hist_entry_t        mem_wdata;

  // Arithmetic units: the shared multiplier and the divider.
  logic               mul_en;
  logic [OPND_W-1:0]  mul_a;
  logic [OPND_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               div_start;
  div_status_t        div_stat;
  logic [NUM_W-1:0]   div_quo;

  logic               issue;
  logic               keep;
  logic [STAMP_W-1:0] dt;
  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  diff_abs;
  logic [ERR_W-1:0]   aerr;
  logic [OPND_W-1:0]  arate;
  logic               rate_neg;
  logic               rate_zero;
  logic               same_sign;
  logic               patient;
  logic               fire;
  logic [PROD_W-AMP_SHIFT-1:0] amp_wide;
  logic [AMP_W-1:0]   amp_sat;
  logic               out_free;

  assign in_stall      = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_amplitude = out_amp_r;
  assign out_free      = !out_valid_r || !out_stall;

  // Eviction sweep: a read is issued per cycle and its data is judged in the cycle after.
  assign issue = (state_r == S_EVICT) && (rd_idx_r != count_r);
  assign keep  = (stamp_r - rd_data_r.stamp) < {8'd0, max_age_r};
  assign dt    = stamp_r - old_stamp_r;

  assign diff     = {err_r[ERR_W-1], err_r} - {old_err_r[ERR_W-1], old_err_r};
  assign diff_abs = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
  assign aerr     = err_r[ERR_W-1] ? (ERR_W'(0) - err_r) : err_r;

  // Rate magnitude after saturation to a signed 32-bit value.
  always_comb begin
    if (!rate_on_r) begin
      arate = '0;
    end else if (diff_neg_r) begin
      arate = (div_quo > RATE_NEG_MAX) ? RATE_NEG_MAX[OPND_W-1:0] : div_quo[OPND_W-1:0];
    end else begin
      arate = (div_quo > RATE_POS_MAX) ? RATE_POS_MAX[OPND_W-1:0] : div_quo[OPND_W-1:0];
    end
  end

  assign rate_neg  = rate_on_r && diff_neg_r && (div_quo != '0);
  assign rate_zero = arate < {1'b0, rate_thr_r};
  assign same_sign = (err_r[ERR_W-1] == rate_neg);
  assign patient   = corrected_r && ((stamp_r - last_stamp_r) < {8'd0, patience_r});
  assign fire      = !patient && (aerr > {2'b0, err_thr_r}) && (rate_zero || same_sign);

  assign amp_wide = mul_p[PROD_W-1:AMP_SHIFT];
  assign amp_sat  = (|amp_wide[PROD_W-AMP_SHIFT-1:AMP_W]) ? AMP_MAX : amp_wide[AMP_W-1:0];

  // Memory write port: survivors during the sweep, the new entry on append.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_data_r;
    if (state_r == S_EVICT) begin
      mem_we = pv_r && keep;
    end else if (state_r == S_APPEND) begin
      mem_we          = 1'b1;
      mem_wdata.stamp = stamp_r;
      mem_wdata.error = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wr_ptr_r] <= mem_wdata;
    end
    rd_data_r <= hist_mem[rd_ptr_r];
  end

  // Multiplier operands: rate numerator, squared error, then gain times square.
  // The product is held otherwise, so the amplitude survives a stalled output.
  assign mul_en = (state_r == S_NUM) || (state_r == S_SQ) || (state_r == S_AMP);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_NUM) begin
      mul_a = OPND_W'(diff_abs);
      mul_b = US_PER_S;
    end else if (state_r == S_SQ) begin
      mul_a = OPND_W'(aerr);
      mul_b = OPND_W'(aerr);
    end else if (state_r == S_AMP) begin
      mul_a = OPND_W'(gain_r);
      mul_b = mul_p[OPND_W-1:0];
    end
  end

  assign div_start = (state_r == S_DSTART);

  skc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  skc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_p[NUM_W-1:0]),
    .den   (dt),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        if (!issue && !pv_r) begin
          state_nxt = ((kept_r == '0) || (dt == '0)) ? S_APPEND : S_NUM;
        end
      end
      S_NUM:    state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) state_nxt = S_APPEND;
      end
      S_APPEND: state_nxt = fire ? S_SQ : S_IDLE;
      S_SQ:     state_nxt = S_AMP;
      S_AMP:    state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      last_stamp_r <= '0;
      corrected_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_idx_r     <= '0;
      kept_r       <= '0;
      pv_r         <= 1'b0;
      rate_on_r    <= 1'b0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;

      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rd_idx_r  <= '0;
            rd_ptr_r  <= head_r;
            wr_ptr_r  <= head_r;
            kept_r    <= '0;
            rate_on_r <= 1'b0;
          end
        end
        S_EVICT: begin
          if (issue) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            rd_ptr_r <= ptr_inc(rd_ptr_r);
          end
          if (pv_r && keep) begin
            kept_r   <= kept_r + 1'b1;
            wr_ptr_r <= ptr_inc(wr_ptr_r);
          end
        end
        S_DIV: begin
          if (div_stat.done) rate_on_r <= 1'b1;
        end
        S_APPEND: begin
          // With the ring full, the oldest entry goes and the new one lands in its slot.
          if (kept_r == DEPTH_CNT) begin
            head_r  <= ptr_inc(head_r);
            count_r <= DEPTH_CNT;
          end else begin
            count_r <= kept_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            last_stamp_r <= stamp_r;
            corrected_r  <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      stamp_r <= in_stamp_us;
      err_r   <= {in_target_size[SIZE_W-1], in_target_size}
               - {in_measured_size[SIZE_W-1], in_measured_size};
    end
    if ((state_r == S_EVICT) && pv_r && keep && (kept_r == '0)) begin
      old_stamp_r <= rd_data_r.stamp;
      old_err_r   <= rd_data_r.error;
    end
    if (state_r == S_NUM) begin
      diff_neg_r <= diff[DIFF_W-1];
    end
    if ((state_r == S_OUT) && out_free) begin
      out_amp_r <= amp_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RST;
      max_age_r  <= MAX_AGE_RST;
      patience_r <= PATIENCE_RST;
      err_thr_r  <= ERR_THR_RST;
      rate_thr_r <= RATE_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN:     gain_r     <= cfg_data[GAIN_W-1:0];
        CFG_MAX_AGE:  max_age_r  <= cfg_data[AGE_W-1:0];
        CFG_PATIENCE: patience_r <= cfg_data[AGE_W-1:0];
        CFG_ERR_THR:  err_thr_r  <= cfg_data[ETHR_W-1:0];
        CFG_RATE_THR: rate_thr_r <= cfg_data[RTHR_W-1:0];
        default: begin
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `SKC_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DEPTH_CNT)
  `SKC_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
  `SKC_ASSERT_IMP(a_div_free_at_start, div_start, !div_stat.busy)
  `SKC_ASSERT_IMP(a_compaction_order, state_r == S_EVICT, kept_r <= rd_idx_r)
  `SKC_ASSERT_IMP(a_result_from_seq, $rose(out_valid_r), $past(state_r) == S_OUT)

endmodule

`default_nettype wire

// ----- hw/rtl/skc_mul.sv -----
`default_nettype none

// Shared unsigned multiplier with a registered product.
// The product register only loads while en is high, so a result can be held.
module skc_mul import skc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [OPND_W-1:0] a,
  input  wire logic [OPND_W-1:0] b,
  output logic      [PROD_W-1:0] p
);

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ----- hw/rtl/skc_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module skc_div import skc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output div_status_t           stat,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  // The dividend is shifted out of the top of quo_r while quotient bits enter below.
  always_comb begin
    rem_sh  = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_nxt = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skc_pkg::*;

  localparam int HIST_DEPTH    = 16;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 600;
  localparam int IDLE_PCT      = 18;
  localparam int PHASE_REQS    = 200;
  localparam longint TIMEOUT_NS = 64'd8_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic [STAMP_W-1:0]        stamp;
    logic signed [SIZE_W-1:0]  measured;
    logic signed [SIZE_W-1:0]  target;
  } size_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [STAMP_W-1:0]    in_stamp_us = '0;
  logic signed [SIZE_W-1:0] in_measured_size = '0;
  logic signed [SIZE_W-1:0] in_target_size = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [AMP_W-1:0]      out_amplitude;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  size_keeping_speed_corrector_top #(.HISTORY_DEPTH(HIST_DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stamp_us      (in_stamp_us),
    .in_measured_size (in_measured_size),
    .in_target_size   (in_target_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_amplitude    (out_amplitude),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register copies for the predictor.
  logic [GAIN_W-1:0] gain_r     = GAIN_RST;
  logic [AGE_W-1:0]  max_age_r  = MAX_AGE_RST;
  logic [AGE_W-1:0]  patience_r = PATIENCE_RST;
  logic [ETHR_W-1:0] err_thr_r  = ERR_THR_RST;
  logic [RTHR_W-1:0] rate_thr_r = RATE_THR_RST;

  // Predictor state: the history in age order, oldest at the front.
  logic [STAMP_W-1:0] hist_stamp_q[$];
  int                 hist_err_q[$];
  logic [STAMP_W-1:0] last_fix_stamp = '0;
  bit                 fixed_once = 1'b0;

  size_req_t        req_q[$];
  logic [AMP_W-1:0] amp_due_q[$];

  bit calm = 1'b0;
  bit squeeze = 1'b0;
  int unsigned fail_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned amp_cnt = 0;
  int unsigned cfg_cnt = 0;

  // Stimulus generator state.
  logic [STAMP_W-1:0] gen_stamp = '0;
  int                 gen_meas = 0;
  int                 gen_tgt = 0;
  int unsigned        step_max = 60000;

  function automatic bit predict_correction(input size_req_t r, output logic [AMP_W-1:0] amp);
    logic [STAMP_W-1:0] kept_s[$];
    int                 kept_e[$];
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] dt;
    int                 err;
    int                 rate;
    longint             num;
    longint             quot;
    longint             aerr;
    longint             arate;
    longint             prod;
    err = int'($signed(r.target)) - int'($signed(r.measured));
    foreach (hist_stamp_q[i]) begin
      age = r.stamp - hist_stamp_q[i];
      if (age < {8'd0, max_age_r}) begin
        kept_s = {kept_s, hist_stamp_q[i]};
        kept_e = {kept_e, hist_err_q[i]};
      end
    end
    hist_stamp_q = kept_s;
    hist_err_q = kept_e;

    rate = 0;
    if (hist_stamp_q.size() != 0) begin
      dt = r.stamp - hist_stamp_q[0];
      if (dt != 0) begin
        num = longint'(err - hist_err_q[0]) * 64'sd1000000;
        quot = num / longint'({32'd0, dt});
        if (quot > 64'sd2147483647) quot = 64'sd2147483647;
        if (quot < -64'sd2147483648) quot = -64'sd2147483648;
        rate = int'(quot);
      end
    end

    if (hist_stamp_q.size() >= HIST_DEPTH) begin
      void'(hist_stamp_q.pop_front());
      void'(hist_err_q.pop_front());
    end
    hist_stamp_q = {hist_stamp_q, r.stamp};
    hist_err_q = {hist_err_q, err};

    amp = '0;
    age = r.stamp - last_fix_stamp;
    if (fixed_once && age < {8'd0, patience_r}) return 1'b0;
    aerr = (err < 0) ? -longint'(err) : longint'(err);
    if (aerr <= longint'(err_thr_r)) return 1'b0;
    arate = (rate < 0) ? -longint'(rate) : longint'(rate);
    // A zero rate counts as positive.
    if (!(arate < longint'(rate_thr_r) || ((err < 0) == (rate < 0)))) return 1'b0;
    prod = (longint'(gain_r) * aerr * aerr) >>> AMP_SHIFT;
    amp = (prod > longint'(AMP_MAX)) ? AMP_MAX : prod[AMP_W-1:0];
    last_fix_stamp = r.stamp;
    fixed_once = 1'b1;
    return 1'b1;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    size_req_t        nxt;
    logic [AMP_W-1:0] amp;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_correction({in_stamp_us, in_measured_size, in_target_size}, amp))
          amp_due_q = {amp_due_q, amp};
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = req_q.pop_front();
          in_valid         <= 1'b1;
          in_stamp_us      <= nxt.stamp;
          in_measured_size <= nxt.measured;
          in_target_size   <= nxt.target;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    logic [AMP_W-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        amp_cnt++;
        if (amp_due_q.size() == 0) begin
          $error("amplitude: expected no correction, actual %0d", out_amplitude);
          fail_cnt++;
        end else begin
          want = amp_due_q.pop_front();
          if (out_amplitude !== want) begin
            $error("amplitude: expected %0d, actual %0d", want, out_amplitude);
            fail_cnt++;
          end
        end
      end
      if (squeeze && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall <= (squeeze && !hold_done) || hold_left > 1 ||
                   (!calm && $urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_cnt++;
    case (idx)
      CFG_GAIN:     gain_r     = val[GAIN_W-1:0];
      CFG_MAX_AGE:  max_age_r  = val[AGE_W-1:0];
      CFG_PATIENCE: patience_r = val[AGE_W-1:0];
      CFG_ERR_THR:  err_thr_r  = val[ETHR_W-1:0];
      CFG_RATE_THR: rate_thr_r = val[RTHR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] age,
                           input logic [CFG_DATA_W-1:0] pat, input logic [CFG_DATA_W-1:0] ethr,
                           input logic [CFG_DATA_W-1:0] rthr);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_MAX_AGE, age);
    write_reg(CFG_PATIENCE, pat);
    write_reg(CFG_ERR_THR, ethr);
    write_reg(CFG_RATE_THR, rthr);
  endtask

  // Waits until every request has been taken and every correction has come back,
  // then lets the block finish any request that yields nothing.
  task automatic drain();
    while (req_q.size() != 0 || in_valid || amp_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_req(input logic [STAMP_W-1:0] stamp, input int meas, input int tgt);
    size_req_t r;
    r.stamp = stamp;
    r.measured = meas[SIZE_W-1:0];
    r.target = tgt[SIZE_W-1:0];
    req_q = {req_q, r};
  endtask

  // Mostly steady tracking with drifting size; the rest repeats stamps, jumps in
  // time or throws in extreme sizes.
  task automatic queue_random(input int n);
    int pick;
    @(negedge clk);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        gen_stamp += ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(step_max);
        gen_meas = gen_meas + int'($urandom_range(4000)) - 2000;
        if (gen_meas > 32767) gen_meas = 32767;
        else if (gen_meas < -32768) gen_meas = -32768;
        if ($urandom_range(19) == 0) gen_tgt = $signed(16'($urandom()));
      end else if (pick < 82) begin
        gen_meas = $signed(16'($urandom()));
      end else if (pick < 92) begin
        gen_stamp = $urandom();
        gen_meas = $signed(16'($urandom()));
        gen_tgt = $signed(16'($urandom()));
      end else begin
        gen_stamp += $urandom_range(200);
        gen_meas = pick[0] ? 32767 : -32768;
        gen_tgt = ($urandom_range(1) == 0) ? -gen_meas - 1 : $signed(16'($urandom()));
      end
      push_req(gen_stamp, gen_meas, gen_tgt);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on reset settings: empty history, full-scale errors,
    // patience, equal stamps, saturated rates, a stamp out of order, and a
    // history that fills while the stamp wraps past zero.
    @(negedge clk);
    push_req(32'h0000_0000, 0, 0);
    push_req(32'h0000_03E8, -32768, 32767);
    push_req(32'h0000_07D0, 32767, -32768);
    push_req(32'h8000_0000, -32768, 32767);
    push_req(32'h8000_0000, 0, 0);
    push_req(32'h8000_0001, 32767, -32768);
    push_req(32'h7FFF_0000, 0, 0);
    for (int k = 0; k < 18; k++)
      push_req(32'hFFFF_FFF0 + 15 * k, 1800 * k - 16000, -(k % 3) * 5000);
    drain();

    gen_stamp = $urandom();
    step_max = 60000;
    queue_random(PHASE_REQS);
    drain();

    // Loosest triggering, largest gain; the receiver holds off for a while.
    write_all(32'h0003_FFFF, 32'h00FF_FFFF, 32'd0, 32'd0, 32'd0);
    step_max = 200000;
    queue_random(PHASE_REQS);
    squeeze <= 1'b1;
    drain();

    // Tightest triggering, zero gain, no history kept.
    write_all(32'd0, 32'd0, 32'h00FF_FFFF, 32'h0000_7FFF, 32'h7FFF_FFFF);
    step_max = 50000;
    queue_random(PHASE_REQS);
    drain();

    // Random settings, raw words, no idling on either side.
    write_all($urandom(), $urandom_range(3000000, 20000), $urandom_range(300000),
              $urandom_range(4000), $urandom_range(2000000));
    step_max = max_age_r / 8 + 1;
    calm <= 1'b1;
    queue_random(PHASE_REQS);
    drain();
    calm <= 1'b0;

    // Very short history window with fine stamp steps.
    write_all($urandom_range(262143), 32'd1000, 32'd0, $urandom_range(500),
              $urandom_range(100000));
    step_max = 200;
    queue_random(PHASE_REQS);
    drain();

    write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    write_reg(CFG_SPARE, $urandom());
    step_max = max_age_r / 8 + 1;
    queue_random(PHASE_REQS);
    drain();

    write_all(GAIN_RST, MAX_AGE_RST, PATIENCE_RST, ERR_THR_RST, RATE_THR_RST);
    step_max = 60000;
    queue_random(PHASE_REQS);
    drain();

    $display("Covered %0d size requests and %0d corrections over %0d register writes,",
             sent_cnt, amp_cnt, cfg_cnt);
    $display("including register extremes, stamp wrap and a long receiver hold-off.");
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/skc_pkg.sv
hw/rtl/skc_mul.sv
hw/rtl/skc_div.sv
hw/rtl/size_keeping_speed_corrector_top.sv
tb/tb.sv
